FILE: sv/lrs_pkg.sv
// lrs_pkg: shared types and constants for the link reconnect supervisor
// request and result payloads, register map, op and link state codes
// no dependencies
package lrs_pkg;

    // default widths of the internal time and attempt counters
    localparam int TIME_BITS_DEF    = 32;
    localparam int ATTEMPT_BITS_DEF = 16;

    // configuration register widths and byte address width
    localparam int TMO_W   = 24;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register index (byte address bits [3:2])
    localparam logic [1:0] REG_LINK_ENABLED = 2'd0;
    localparam logic [1:0] REG_FIRST_TMO    = 2'd1;
    localparam logic [1:0] REG_RETRY_TMO    = 2'd2;
    localparam logic [1:0] REG_RETRY_DELAY  = 2'd3;

    // register reset values
    localparam logic             LINK_ENABLED_RST = 1'b1;
    localparam logic [TMO_W-1:0] FIRST_TMO_RST    = 24'd20000;
    localparam logic [TMO_W-1:0] RETRY_TMO_RST    = 24'd10000;
    localparam logic [TMO_W-1:0] RETRY_DELAY_RST  = 24'd5000;

    // request kinds
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // link state codes as reported in the result
    localparam logic [1:0] LINK_DISABLED   = 2'd0;
    localparam logic [1:0] LINK_CONNECTING = 2'd1;
    localparam logic [1:0] LINK_CONNECTED  = 2'd2;
    localparam logic [1:0] LINK_WAITING    = 2'd3;

    typedef struct packed {
        logic             link_enabled;
        logic [TMO_W-1:0] first_timeout_ms;
        logic [TMO_W-1:0] retry_timeout_ms;
        logic [TMO_W-1:0] retry_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        link_up;
    } in_t;

    typedef struct packed {
        logic [1:0]  link_state;
        logic [15:0] attempt_count;
        logic        start_attempt;
        logic        just_connected;
        logic [31:0] connect_time_ms;
    } out_t;

endpackage

FILE: sv/lrs_cfg_regs.sv
// lrs_cfg_regs: APB-style configuration registers of the supervisor
// depends on lrs_pkg for the register map, reset values and cfg_t
module lrs_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [lrs_pkg::PDATA_W-1:0]  pwdata,
    output logic [lrs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output lrs_pkg::cfg_t                cfg
);
    import lrs_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_enabled     <= LINK_ENABLED_RST;
            cfg_reg.first_timeout_ms <= FIRST_TMO_RST;
            cfg_reg.retry_timeout_ms <= RETRY_TMO_RST;
            cfg_reg.retry_delay_ms   <= RETRY_DELAY_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LINK_ENABLED: cfg_reg.link_enabled     <= pwdata[0];
                REG_FIRST_TMO:    cfg_reg.first_timeout_ms <= pwdata[TMO_W-1:0];
                REG_RETRY_TMO:    cfg_reg.retry_timeout_ms <= pwdata[TMO_W-1:0];
                REG_RETRY_DELAY:  cfg_reg.retry_delay_ms   <= pwdata[TMO_W-1:0];
                default:          ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_LINK_ENABLED: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.link_enabled};
            REG_FIRST_TMO:    prdata = {{(PDATA_W-TMO_W){1'b0}}, cfg_reg.first_timeout_ms};
            REG_RETRY_TMO:    prdata = {{(PDATA_W-TMO_W){1'b0}}, cfg_reg.retry_timeout_ms};
            REG_RETRY_DELAY:  prdata = {{(PDATA_W-TMO_W){1'b0}}, cfg_reg.retry_delay_ms};
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: sv/lrs_fsm.sv
// lrs_fsm: connection state, timers and attempt counter; computes the result
// of the request held in the input stage and updates state when it advances
// depends on lrs_pkg for cfg_t, in_t, out_t and the state codes
module lrs_fsm #(
    parameter int TIME_BITS    = lrs_pkg::TIME_BITS_DEF,
    parameter int ATTEMPT_BITS = lrs_pkg::ATTEMPT_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lrs_pkg::cfg_t  cfg,
    input  logic           step,
    input  lrs_pkg::in_t   req,
    output lrs_pkg::out_t  rsp
);
    import lrs_pkg::*;

    typedef enum logic [1:0] {
        MODE_DISABLED   = LINK_DISABLED,
        MODE_CONNECTING = LINK_CONNECTING,
        MODE_CONNECTED  = LINK_CONNECTED,
        MODE_WAITING    = LINK_WAITING
    } mode_t;

    localparam logic [ATTEMPT_BITS-1:0] ATT_MAX = '1;
    localparam logic [ATTEMPT_BITS-1:0] ATT_ONE = ATTEMPT_BITS'(1);

    mode_t                   mode_reg, mode_next;
    logic [TIME_BITS-1:0]    since_reg, since_next;
    logic [TIME_BITS-1:0]    first_reg, first_next;
    logic [ATTEMPT_BITS-1:0] attempts_reg, attempts_next;

    logic [TIME_BITS+31:0]     now_wide;
    logic [TIME_BITS-1:0]      now_t;
    logic [TIME_BITS-1:0]      elapsed;
    logic [TIME_BITS-1:0]      conn_el;
    logic [TIME_BITS+31:0]     conn_wide;
    logic [TIME_BITS+TMO_W-1:0] elapsed_cmp;
    logic [TMO_W-1:0]          limit;
    logic                      connect_expired;
    logic                      delay_expired;
    logic [ATTEMPT_BITS-1:0]   attempts_inc;
    logic [ATTEMPT_BITS+15:0]  att_wide;
    logic                      start;
    logic                      joined;

    // time in the counter width, wrap-around differences
    assign now_wide    = {{TIME_BITS{1'b0}}, req.now_ms};
    assign now_t       = now_wide[TIME_BITS-1:0];
    assign elapsed     = now_t - since_reg;
    assign conn_el     = now_t - first_reg;
    assign conn_wide   = {32'b0, conn_el};
    assign elapsed_cmp = {{TMO_W{1'b0}}, elapsed};

    // timeout selection and compares
    assign limit = (attempts_reg[ATTEMPT_BITS-1:1] == '0) ? cfg.first_timeout_ms
                                                          : cfg.retry_timeout_ms;
    assign connect_expired = elapsed_cmp >= {{TIME_BITS{1'b0}}, limit};
    assign delay_expired   = elapsed_cmp >= {{TIME_BITS{1'b0}}, cfg.retry_delay_ms};

    // saturating attempt increment
    assign attempts_inc = (attempts_reg == ATT_MAX) ? attempts_reg : attempts_reg + ATT_ONE;

    // next state for the held request
    always_comb
    begin
        mode_next     = mode_reg;
        since_next    = since_reg;
        first_next    = first_reg;
        attempts_next = attempts_reg;
        start         = 1'b0;
        joined        = 1'b0;

        if (req.op == OP_BEGIN)
        begin
            if (!cfg.link_enabled)
            begin
                mode_next  = MODE_DISABLED;
                since_next = now_t;
            end
            else
            begin
                start = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_CONNECTING:
                begin
                    if (req.link_up)
                    begin
                        mode_next  = MODE_CONNECTED;
                        since_next = now_t;
                        joined     = 1'b1;
                    end
                    else if (connect_expired)
                    begin
                        mode_next  = MODE_WAITING;
                        since_next = now_t;
                    end
                end
                MODE_CONNECTED:
                begin
                    if (!req.link_up)
                    begin
                        mode_next  = MODE_WAITING;
                        since_next = now_t;
                    end
                end
                MODE_WAITING:
                begin
                    if (delay_expired)
                    begin
                        start = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // new attempt: count, stamp the first one, restart connecting
        if (start)
        begin
            attempts_next = attempts_inc;
            if (attempts_inc == ATT_ONE)
            begin
                first_next = now_t;
            end
            mode_next  = MODE_CONNECTING;
            since_next = now_t;
        end
    end

    // result fields
    assign att_wide = {16'b0, attempts_next};

    always_comb
    begin
        rsp.link_state      = 2'(mode_next);
        rsp.attempt_count   = att_wide[15:0];
        rsp.start_attempt   = start;
        rsp.just_connected  = joined;
        rsp.connect_time_ms = joined ? conn_wide[31:0] : 32'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_DISABLED;
            since_reg    <= '0;
            first_reg    <= '0;
            attempts_reg <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            since_reg    <= since_next;
            first_reg    <= first_next;
            attempts_reg <= attempts_next;
        end
    end

endmodule

FILE: sv/lrs_out_buf.sv
// lrs_out_buf: two-entry result buffer that decouples the result stall
// from the input stage
// depends on lrs_pkg for out_t
module lrs_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lrs_pkg::out_t  push_data,
    output logic           ready,
    output logic           out_valid,
    input  logic           out_stall,
    output lrs_pkg::out_t  out_rsp
);
    import lrs_pkg::*;

    out_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign ready     = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_rsp   = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/link_reconnect_supervisor.sv
// link_reconnect_supervisor: top level; input stage, state machine, result buffer
// depends on lrs_pkg, lrs_cfg_regs, lrs_fsm and lrs_out_buf
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | to block  | in_valid / in_stall   | in_req  (op, now_ms, link_up)
//  out     | from block| out_valid / out_stall | out_rsp (state, count, pulses, time)
//  apb     | to block  | psel/penable/pready   | paddr, pwdata, prdata
//
// one request per clock while in_stall is low; a result is valid once its request has
// passed the input register and then the result buffer; state updates as the request
// leaves the input register.
// reset clears state to disabled with zero timers and count.
// while results are stalled, two sit in the buffer and a third waits in the input
// register, so three requests are taken from an empty block before in_stall rises.
module link_reconnect_supervisor #(
    parameter int TIME_BITS    = lrs_pkg::TIME_BITS_DEF,
    parameter int ATTEMPT_BITS = lrs_pkg::ATTEMPT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  lrs_pkg::in_t                 in_req,
    output logic                         out_valid,
    input  logic                         out_stall,
    output lrs_pkg::out_t                out_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [lrs_pkg::PDATA_W-1:0]  pwdata,
    output logic [lrs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import lrs_pkg::*;

    cfg_t cfg;
    in_t  req_reg;
    logic req_valid_reg;
    out_t step_rsp;
    logic buf_ready;
    logic accept;
    logic advance;

    lrs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage handshake
    assign advance  = req_valid_reg && buf_ready;
    assign in_stall = req_valid_reg && !buf_ready;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_req;
        end
    end

    lrs_fsm #(
        .TIME_BITS    (TIME_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .req   (req_reg),
        .rsp   (step_rsp)
    );

    lrs_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (step_rsp),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

`ifndef SYNTHESIS
    // the input side only stalls while a request is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> req_valid_reg)
        else $error("in_stall raised with empty input stage");

    // a new attempt always leaves the link connecting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_rsp.start_attempt) |-> (out_rsp.link_state == LINK_CONNECTING))
        else $error("start_attempt without connecting state");

    // a connect pulse always reports the connected state and no new attempt
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_rsp.just_connected) |->
            (out_rsp.link_state == LINK_CONNECTED && !out_rsp.start_attempt))
        else $error("just_connected with wrong state or attempt pulse");

    // a held request advances as soon as the buffer has room
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && buf_ready && !accept) |=> !req_valid_reg)
        else $error("input stage did not drain");
`endif

endmodule

FILE: tb/tb_link_reconnect_supervisor.sv
// tb_link_reconnect_supervisor: self-checking testbench for the link reconnect supervisor
// predicts every result from its own copy of the state machine and registers
// depends on lrs_pkg and link_reconnect_supervisor
`timescale 1ns / 1ps

module tb_link_reconnect_supervisor;

    import lrs_pkg::*;

    localparam logic [15:0] ATTEMPT_SAT = 16'hFFFF;
    localparam logic [31:0] WRAP_BASE   = 32'hFFFF_F000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_t                 in_req = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_t                out_rsp;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // predicted supervisor state and register copy
    cfg_t        sup_cfg;
    logic [1:0]  sup_mode;
    logic [31:0] sup_since;
    logic [31:0] sup_first_ms;
    logic [15:0] sup_attempts;

    out_t        expected_results[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_off_cycles = 0;
    logic [31:0] link_clock_ms = '0;

    link_reconnect_supervisor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // start a connect attempt, counter saturates
    function automatic void open_attempt(input logic [31:0] now_ms);
        if (sup_attempts != ATTEMPT_SAT)
            sup_attempts = sup_attempts + 16'd1;
        if (sup_attempts == 16'd1)
            sup_first_ms = now_ms;
        sup_mode  = LINK_CONNECTING;
        sup_since = now_ms;
    endfunction

    // advance the predicted state machine by one request
    function automatic out_t predict_supervisor(input in_t req);
        out_t        res;
        logic [31:0] waited;
        logic [23:0] limit;
        res    = '0;
        waited = req.now_ms - sup_since;
        if (req.op == OP_BEGIN)
        begin
            if (!sup_cfg.link_enabled)
            begin
                sup_mode  = LINK_DISABLED;
                sup_since = req.now_ms;
            end
            else
            begin
                open_attempt(req.now_ms);
                res.start_attempt = 1'b1;
            end
        end
        else
        begin
            case (sup_mode)
                LINK_CONNECTING:
                begin
                    limit = (sup_attempts <= 16'd1) ? sup_cfg.first_timeout_ms
                                                     : sup_cfg.retry_timeout_ms;
                    // link up beats a timeout on the same poll
                    if (req.link_up)
                    begin
                        sup_mode  = LINK_CONNECTED;
                        sup_since = req.now_ms;
                        res.just_connected  = 1'b1;
                        res.connect_time_ms = req.now_ms - sup_first_ms;
                    end
                    else if (waited >= {8'd0, limit})
                    begin
                        sup_mode  = LINK_WAITING;
                        sup_since = req.now_ms;
                    end
                end
                LINK_CONNECTED:
                begin
                    if (!req.link_up)
                    begin
                        sup_mode  = LINK_WAITING;
                        sup_since = req.now_ms;
                    end
                end
                LINK_WAITING:
                begin
                    if (waited >= {8'd0, sup_cfg.retry_delay_ms})
                    begin
                        open_attempt(req.now_ms);
                        res.start_attempt = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.link_state    = sup_mode;
        res.attempt_count = sup_attempts;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // receiver side: random stall plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall       <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker against the oldest prediction
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result state %0d count %0d start %0b %s",
                    out_rsp.link_state, out_rsp.attempt_count, out_rsp.start_attempt,
                    $sformatf("joined %0b ctime %0d", out_rsp.just_connected,
                              out_rsp.connect_time_ms)));
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_rsp.link_state !== want.link_state ||
                    out_rsp.attempt_count !== want.attempt_count ||
                    out_rsp.start_attempt !== want.start_attempt ||
                    out_rsp.just_connected !== want.just_connected ||
                    out_rsp.connect_time_ms !== want.connect_time_ms)
                begin
                    note_failure($sformatf(
                        "mismatch exp state %0d cnt %0d start %0b join %0b ct %0d %s",
                        want.link_state, want.attempt_count, want.start_attempt,
                        want.just_connected, want.connect_time_ms,
                        $sformatf("got state %0d cnt %0d start %0b join %0b ct %0d",
                            out_rsp.link_state, out_rsp.attempt_count,
                            out_rsp.start_attempt, out_rsp.just_connected,
                            out_rsp.connect_time_ms)));
                end
            end
        end
    end

    // send one request, with an optional idle gap ahead of it
    task automatic send_request(input logic op, input logic [31:0] now_ms, input logic up);
        in_t req;
        int  gap;
        req.op      = op;
        req.now_ms  = now_ms;
        req.link_up = up;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_supervisor(req));
    endtask

    // stop offering requests and wait for every pending result
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_LINK_ENABLED: sup_cfg.link_enabled     = value[0];
            REG_FIRST_TMO:    sup_cfg.first_timeout_ms = value[TMO_W-1:0];
            REG_RETRY_TMO:    sup_cfg.retry_timeout_ms = value[TMO_W-1:0];
            REG_RETRY_DELAY:  sup_cfg.retry_delay_ms   = value[TMO_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timers(input logic [31:0] first_ms, input logic [31:0] retry_ms,
                              input logic [31:0] delay_ms);
        write_reg(REG_FIRST_TMO, first_ms);
        write_reg(REG_RETRY_TMO, retry_ms);
        write_reg(REG_RETRY_DELAY, delay_ms);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // mostly in-order time with mode-aware link status, some noise
    task automatic run_link_traffic(input int count, input int step_max);
        int          roll;
        logic        op;
        logic        up;
        logic [31:0] now_ms;
        for (int i = 0; i < count; i++)
        begin
            roll          = $urandom_range(99);
            link_clock_ms = link_clock_ms + $urandom_range(step_max);
            now_ms        = link_clock_ms;
            op            = OP_POLL;
            if (sup_mode == LINK_CONNECTED)
                up = ($urandom_range(7) != 0);
            else
                up = ($urandom_range(5) == 0);
            if (roll < 5)
            begin
                now_ms = $urandom;
                op     = 1'($urandom_range(1));
                up     = 1'($urandom_range(1));
            end
            else if (roll < 9 || (sup_mode == LINK_DISABLED && $urandom_range(3) == 0))
            begin
                op = OP_BEGIN;
            end
            send_request(op, now_ms, up);
        end
    endtask

    // state walk with reset registers, including time wrap
    task automatic test_state_walk();
        send_request(OP_POLL, 32'd0, 1'b1);
        send_request(OP_BEGIN, WRAP_BASE, 1'b0);
        send_request(OP_POLL, WRAP_BASE + 32'd19999, 1'b0);
        send_request(OP_POLL, WRAP_BASE + 32'd20000, 1'b0);
        send_request(OP_POLL, WRAP_BASE + 32'd24999, 1'b1);
        send_request(OP_POLL, WRAP_BASE + 32'd25000, 1'b0);
        send_request(OP_POLL, WRAP_BASE + 32'd34999, 1'b0);
        send_request(OP_POLL, WRAP_BASE + 32'd35000, 1'b1);
        send_request(OP_POLL, WRAP_BASE + 32'd36000, 1'b1);
        send_request(OP_POLL, WRAP_BASE + 32'd36001, 1'b0);
        send_request(OP_BEGIN, 32'd0, 1'b1);
        send_request(OP_POLL, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_BEGIN, 32'h8000_0000, 1'b0);
    endtask

    // disabled link, oversized writes, zero and full-scale timers
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_LINK_ENABLED, 32'hFFFF_FFFE);
        send_request(OP_BEGIN, 32'h1234_5678, 1'b1);
        send_request(OP_POLL, 32'h1234_9999, 1'b1);
        wait_idle();
        write_reg(REG_LINK_ENABLED, 32'h0000_0001);
        set_timers(32'hFF00_0000, 32'hFF00_0000, 32'hAB00_0000);
        send_request(OP_BEGIN, 32'd100, 1'b0);
        send_request(OP_POLL, 32'd100, 1'b0);
        send_request(OP_POLL, 32'd100, 1'b0);
        send_request(OP_POLL, 32'd100, 1'b1);
        wait_idle();
        set_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_BEGIN, 32'd0, 1'b0);
        send_request(OP_POLL, 32'h00FF_FFFE, 1'b0);
        send_request(OP_POLL, 32'h00FF_FFFF, 1'b0);
        send_request(OP_POLL, 32'h01FF_FFFD, 1'b0);
        send_request(OP_POLL, 32'h01FF_FFFE, 1'b0);
    endtask

    // random traffic across register settings and idling mixes
    task automatic test_random_traffic();
        wait_idle();
        set_timers(32'd40, 32'd20, 32'd15);
        set_idling(0, 0);
        link_clock_ms = 32'hFFFF_FF00;
        run_link_traffic(130, 25);
        wait_idle();
        set_timers(32'd10, 32'd3, 32'd0);
        set_idling(55, 0);
        run_link_traffic(130, 8);
        wait_idle();
        set_timers(32'd20000, 32'd10000, 32'd5000);
        set_idling(0, 55);
        run_link_traffic(130, 9000);
        wait_idle();
        write_reg(REG_LINK_ENABLED, 32'd0);
        set_timers(32'd1, 32'd1, 32'd1);
        set_idling(33, 33);
        run_link_traffic(40, 4);
        wait_idle();
        write_reg(REG_LINK_ENABLED, 32'd1);
        set_timers(32'd5, 32'd2, 32'd7);
        link_clock_ms = $urandom;
        run_link_traffic(130, 6);
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        wait_idle();
        set_idling(0, 0);
        hold_off_cycles = 60;
        run_link_traffic(25, 10);
        @(negedge clk);
        in_valid <= 1'b0;
        while (hold_off_cycles > 0)
            @(posedge clk);
    endtask

    // back-to-back begins with zero timers push the attempt counter, then mixed requests
    task automatic test_attempt_burst();
        wait_idle();
        set_timers(32'd0, 32'd0, 32'd0);
        set_idling(0, 0);
        for (int i = 0; i < 40 && sup_attempts != ATTEMPT_SAT; i++)
            send_request(OP_BEGIN, $urandom, 1'($urandom_range(1)));
        for (int i = 0; i < 6; i++)
            send_request(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
    endtask

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int spin;
        sup_cfg      = '{LINK_ENABLED_RST, FIRST_TMO_RST, RETRY_TMO_RST, RETRY_DELAY_RST};
        sup_mode     = LINK_DISABLED;
        sup_since    = '0;
        sup_first_ms = '0;
        sup_attempts = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_state_walk();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_attempt_burst();

        // drain, then let the pipeline settle
        @(negedge clk);
        in_valid <= 1'b0;
        spin = 0;
        while (expected_results.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lrs_pkg.sv
sv/lrs_cfg_regs.sv
sv/lrs_fsm.sv
sv/lrs_out_buf.sv
sv/link_reconnect_supervisor.sv
tb/tb_link_reconnect_supervisor.sv
